### rtl/core/dlfp_pkg.sv
// Shared types and codes of the device length frame parser.
package dlfp_pkg;

   typedef enum logic [1:0] {
      CMD_BYTE   = 2'd0,
      CMD_RESYNC = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_INVALID  = 3'd1,
      EV_READ     = 3'd2,
      EV_ZERO_LEN = 3'd3,
      EV_RESYNC   = 3'd4
   } event_type;

   localparam logic [7:0] READ_FLAG = 8'h80;
   localparam logic [7:0] DEV_MASK  = 8'h7F;

   // One result word, without the statistics counters
   typedef struct packed {
      logic       payload_valid;
      logic [3:0] device_number;
      logic [7:0] payload_byte;
      logic       last_of_frame;
      event_type  event_code;
   } beat_type;

   // Counter updates requested by the parser for one word
   typedef struct packed {
      logic clear;
      logic inc_byte;
      logic inc_dispatch;
      logic inc_invalid;
      logic inc_read;
      logic inc_overrun;
   } count_ctl_type;

endpackage

### rtl/core/dlfp_core.sv
// Frame parse state and per-word decode of the device length frame parser.
module dlfp_core import dlfp_pkg::*; #(
   parameter int NUM_DEVICES = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic [1:0]    cmd,
   input  logic [7:0]    data_byte,
   input  logic [15:0]   enable_mask,
   output beat_type      beat,
   output count_ctl_type count_ctl
);

   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_GOT_DEVICE = 2'd1,
      PH_RECEIVING  = 2'd2
   } phase_type;

   localparam logic [7:0] NumDevices = 8'(NUM_DEVICES);

   phase_type  phase_ff, phase_in;
   logic [3:0] active_ff, active_in;
   logic       beyond_ff, beyond_in;
   logic [7:0] left_ff, left_in;

   logic [7:0] dev_num;
   logic [7:0] left_dec;
   logic       fin;
   logic       enabled;

   assign dev_num  = data_byte & DEV_MASK;
   assign left_dec = left_ff - 8'd1;
   assign fin      = (left_dec == 8'd0);
   assign enabled  = !beyond_ff && enable_mask[active_ff];

   always_comb begin
      phase_in  = phase_ff;
      active_in = active_ff;
      beyond_in = beyond_ff;
      left_in   = left_ff;
      beat.payload_valid = 1'b0;
      beat.device_number = 4'd0;
      beat.payload_byte  = 8'd0;
      beat.last_of_frame = 1'b0;
      beat.event_code    = EV_NONE;
      count_ctl = '0;
      case (cmd)
         CMD_RESYNC: begin
            phase_in = PH_IDLE;
            left_in  = 8'd0;
            count_ctl.inc_overrun = 1'b1;
            beat.event_code = EV_RESYNC;
         end
         CMD_CLEAR: begin
            count_ctl.clear = 1'b1;
         end
         CMD_BYTE: begin
            count_ctl.inc_byte = 1'b1;
            case (phase_ff)
               PH_GOT_DEVICE: begin
                  left_in = data_byte;
                  if (data_byte == 8'd0) begin
                     phase_in = PH_IDLE;
                     beat.event_code = EV_ZERO_LEN;
                  end else begin
                     phase_in = PH_RECEIVING;
                  end
               end
               PH_RECEIVING: begin
                  left_in = left_dec;
                  if (enabled) begin
                     beat.payload_valid = 1'b1;
                     beat.device_number = active_ff;
                     beat.payload_byte  = data_byte;
                     beat.last_of_frame = fin;
                     count_ctl.inc_dispatch = fin;
                  end
                  if (fin) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  // device byte; the unused phase code behaves as idle
                  phase_in = PH_IDLE;
                  if (dev_num >= NumDevices) begin
                     count_ctl.inc_invalid = 1'b1;
                     beat.event_code = EV_INVALID;
                  end else begin
                     active_in = dev_num[3:0];
                     beyond_in = (dev_num[6:4] != 3'd0);
                     if ((data_byte & READ_FLAG) != 8'd0) begin
                        count_ctl.inc_read = 1'b1;
                        beat.event_code = EV_READ;
                     end else begin
                        phase_in = PH_GOT_DEVICE;
                     end
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         active_ff <= 4'd0;
         beyond_ff <= 1'b0;
         left_ff   <= 8'd0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         active_ff <= active_in;
         beyond_ff <= beyond_in;
         left_ff   <= left_in;
      end
   end

`ifndef SYNTHESIS
   a_recv_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_RECEIVING |-> left_ff != 8'd0)
      else $error("receiving with no bytes left");

   a_invalid_to_idle: assert property (@(posedge clock) disable iff (reset)
      advance && beat.event_code == EV_INVALID |=> phase_ff == PH_IDLE)
      else $error("invalid device did not leave parser idle");

   a_last_counts_frame: assert property (@(posedge clock) disable iff (reset)
      beat.last_of_frame |-> beat.payload_valid && count_ctl.inc_dispatch)
      else $error("last word without frame dispatch");
`endif

endmodule

### rtl/core/dlfp_counters.sv
// Wrapping 32-bit statistics counters of the device length frame parser.
module dlfp_counters import dlfp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  count_ctl_type count_ctl,
   output logic [31:0]   bytes_received,
   output logic [31:0]   frames_dispatched,
   output logic [31:0]   invalid_devices,
   output logic [31:0]   read_requests,
   output logic [31:0]   overruns
);

   logic [31:0] bytes_ff, bytes_in;
   logic [31:0] frames_ff, frames_in;
   logic [31:0] invalid_ff, invalid_in;
   logic [31:0] reads_ff, reads_in;
   logic [31:0] overruns_ff, overruns_in;

   always_comb begin
      if (count_ctl.clear) begin
         bytes_in    = 32'd0;
         frames_in   = 32'd0;
         invalid_in  = 32'd0;
         reads_in    = 32'd0;
         overruns_in = 32'd0;
      end else begin
         bytes_in    = bytes_ff    + 32'(count_ctl.inc_byte);
         frames_in   = frames_ff   + 32'(count_ctl.inc_dispatch);
         invalid_in  = invalid_ff  + 32'(count_ctl.inc_invalid);
         reads_in    = reads_ff    + 32'(count_ctl.inc_read);
         overruns_in = overruns_ff + 32'(count_ctl.inc_overrun);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff    <= 32'd0;
         frames_ff   <= 32'd0;
         invalid_ff  <= 32'd0;
         reads_ff    <= 32'd0;
         overruns_ff <= 32'd0;
      end else if (advance) begin
         bytes_ff    <= bytes_in;
         frames_ff   <= frames_in;
         invalid_ff  <= invalid_in;
         reads_ff    <= reads_in;
         overruns_ff <= overruns_in;
      end
   end

   assign bytes_received    = bytes_ff;
   assign frames_dispatched = frames_ff;
   assign invalid_devices   = invalid_ff;
   assign read_requests     = reads_ff;
   assign overruns          = overruns_ff;

endmodule

### rtl/core/device_length_frame_parser.sv
// Device length frame parser: one result word for every accepted input word,
// in order. Each word passes an input register, then the result register,
// and a new word is taken every clock while rsp_ready does not stall the
// output, so sustained throughput is one word per cycle; the result register
// holds a word while the next is already in the input register. The statistics
// counters are updated in the same edge that loads the result register, so the
// counter outputs always show the values after the word being presented.
// The enable mask is written through the csr_ port and sampled per payload word.
module device_length_frame_parser import dlfp_pkg::*; #(
   parameter int NUM_DEVICES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_device_enable_mask,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_payload_valid,
   output logic [3:0]  rsp_device_number,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_of_frame,
   output logic [2:0]  rsp_event_code,
   output logic [31:0] rsp_bytes_received,
   output logic [31:0] rsp_frames_dispatched,
   output logic [31:0] rsp_invalid_devices,
   output logic [31:0] rsp_read_requests,
   output logic [31:0] rsp_overruns
);

   logic [15:0]   mask_ff;
   logic          in_valid_ff;
   logic [1:0]    cmd_ff;
   logic [7:0]    byte_ff;
   logic          out_valid_ff;
   beat_type      beat_ff;
   beat_type      beat_in;
   count_ctl_type count_ctl;
   logic          advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= 16'd0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            mask_ff <= csr_device_enable_mask;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff  <= req_cmd;
         byte_ff <= req_data_byte;
      end
      if (advance) begin
         beat_ff <= beat_in;
      end
   end

   dlfp_core #(
      .NUM_DEVICES (NUM_DEVICES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .cmd         (cmd_ff),
      .data_byte   (byte_ff),
      .enable_mask (mask_ff),
      .beat        (beat_in),
      .count_ctl   (count_ctl)
   );

   dlfp_counters u_counters (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .count_ctl         (count_ctl),
      .bytes_received    (rsp_bytes_received),
      .frames_dispatched (rsp_frames_dispatched),
      .invalid_devices   (rsp_invalid_devices),
      .read_requests     (rsp_read_requests),
      .overruns          (rsp_overruns)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_valid = beat_ff.payload_valid;
   assign rsp_device_number = beat_ff.device_number;
   assign rsp_payload_byte  = beat_ff.payload_byte;
   assign rsp_last_of_frame = beat_ff.last_of_frame;
   assign rsp_event_code    = beat_ff.event_code;

endmodule
